FILE: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// clocked concurrent assertion helpers used by the checker file dwpid_chk.sv
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge out of reset
`define ASSERT_CLK(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true out of reset
`define ASSERT_NEVER(name, clk, rst_n, expr, msg) \
    `ASSERT_CLK(name, clk, rst_n, !(expr), msg)

`endif

FILE: hdl/dwpid_pkg.sv
// ---------------------------------------------------------------------------
// dwpid_pkg
// shared widths, register indexes, reset values and types of the dual wheel
// pid distance controller
// ---------------------------------------------------------------------------
package dwpid_pkg;

    // parameter defaults
    localparam int DEF_COUNT_WIDTH    = 16;
    localparam int DEF_GAIN_FRAC_BITS = 8;

    // fixed field widths
    localparam int TARGET_W   = 16;
    localparam int GAIN_W     = 16;
    localparam int SPEED_W    = 7;
    localparam int TIMEOUT_W  = 16;
    localparam int WINDOW_W   = 8;
    localparam int INTEG_W    = 32;
    localparam int DRIVE_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TARGET  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW  = 3'd7;

    // register reset values
    localparam logic [TARGET_W-1:0]  RST_TARGET  = 16'd0;
    localparam logic [GAIN_W-1:0]    RST_GAIN_P  = 16'd154;
    localparam logic [GAIN_W-1:0]    RST_GAIN_I  = 16'd13;
    localparam logic [GAIN_W-1:0]    RST_GAIN_D  = 16'd1280;
    localparam logic [SPEED_W-1:0]   RST_SPEED   = 7'd127;
    localparam logic                 RST_REVERSE = 1'b0;
    localparam logic [TIMEOUT_W-1:0] RST_TIMEOUT = 16'd100;
    localparam logic [WINDOW_W-1:0]  RST_WINDOW  = 8'd20;

    // drive limit and speed divisor
    localparam int DRIVE_MAX = 127;
    localparam int SPEED_DIV = 127;

    // 129 / 2^14 sits just under 1/127, one correction step fixes the quotient
    localparam int RECIP_MUL   = 129;
    localparam int RECIP_SHIFT = 14;

    typedef struct packed {
        logic [TARGET_W-1:0]  target;
        logic [GAIN_W-1:0]    gain_prop;
        logic [GAIN_W-1:0]    gain_integ;
        logic [GAIN_W-1:0]    gain_deriv;
        logic [SPEED_W-1:0]   speed;
        logic                 reverse;
        logic [TIMEOUT_W-1:0] timeout;
        logic [WINDOW_W-1:0]  window;
    } t_cfg;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic err;
        logic mul;
        logic acc;
        logic mag;
        logic scl;
        logic div;
        logic fin;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic skip;
        logic out_full;
    } t_dp_status;

endpackage

FILE: hdl/dwpid_ifs.sv
// ---------------------------------------------------------------------------
// dwpid channel interfaces
// valid/ready channels for the tick input, the drive result and the
// register write port
// ---------------------------------------------------------------------------

// tick input channel
interface dwpid_in_if import dwpid_pkg::*; #(
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) ();
    logic                          valid;
    logic                          ready;
    logic                          start_req;
    logic signed [COUNT_WIDTH-1:0] left_count;
    logic signed [COUNT_WIDTH-1:0] right_count;

    modport source (output valid, output start_req, output left_count,
                    output right_count, input ready);
    modport sink (input valid, input start_req, input left_count,
                  input right_count, output ready);
endinterface

// drive result channel
interface dwpid_out_if import dwpid_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [DRIVE_W-1:0] left_drive;
    logic signed [DRIVE_W-1:0] right_drive;
    logic                      timed_out;

    modport source (output valid, output left_drive, output right_drive,
                    output timed_out, input ready);
    modport sink (input valid, input left_drive, input right_drive,
                  input timed_out, output ready);
endinterface

// register write channel
interface dwpid_cfg_if import dwpid_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hdl/dwpid_regs.sv
// ---------------------------------------------------------------------------
// dwpid_regs
// configuration register file, one write per accepted item on the write port
// ---------------------------------------------------------------------------
module dwpid_regs import dwpid_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_valid,
    input  logic [CFG_IDX_W-1:0]  i_wr_index,
    input  logic [CFG_DATA_W-1:0] i_wr_data,
    output logic                  o_wr_ready,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    // writes are always taken
    assign o_wr_ready = 1'b1;
    assign o_cfg      = r_cfg;

    // register write decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target     <= RST_TARGET;
            r_cfg.gain_prop  <= RST_GAIN_P;
            r_cfg.gain_integ <= RST_GAIN_I;
            r_cfg.gain_deriv <= RST_GAIN_D;
            r_cfg.speed      <= RST_SPEED;
            r_cfg.reverse    <= RST_REVERSE;
            r_cfg.timeout    <= RST_TIMEOUT;
            r_cfg.window     <= RST_WINDOW;
        end else if (i_wr_valid) begin
            unique case (i_wr_index)
                REG_TARGET:  r_cfg.target     <= i_wr_data[TARGET_W-1:0];
                REG_GAIN_P:  r_cfg.gain_prop  <= i_wr_data[GAIN_W-1:0];
                REG_GAIN_I:  r_cfg.gain_integ <= i_wr_data[GAIN_W-1:0];
                REG_GAIN_D:  r_cfg.gain_deriv <= i_wr_data[GAIN_W-1:0];
                REG_SPEED:   r_cfg.speed      <= i_wr_data[SPEED_W-1:0];
                REG_REVERSE: r_cfg.reverse    <= i_wr_data[0];
                REG_TIMEOUT: r_cfg.timeout    <= i_wr_data[TIMEOUT_W-1:0];
                REG_WINDOW:  r_cfg.window     <= i_wr_data[WINDOW_W-1:0];
            endcase
        end
    end

endmodule

FILE: hdl/dwpid_ctrl.sv
// ---------------------------------------------------------------------------
// dwpid_ctrl
// sequencer that steps one tick through the datapath stages
// ---------------------------------------------------------------------------
module dwpid_ctrl import dwpid_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ERR  = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_ACC  = 3'd3;
    localparam logic [2:0] S_MAG  = 3'd4;
    localparam logic [2:0] S_SCL  = 3'd5;
    localparam logic [2:0] S_DIV  = 3'd6;
    localparam logic [2:0] S_FIN  = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_ERR;
            S_ERR:  n_state = i_status.skip ? S_FIN : S_MUL;
            S_MUL:  n_state = S_ACC;
            S_ACC:  n_state = S_MAG;
            S_MAG:  n_state = S_SCL;
            S_SCL:  n_state = S_DIV;
            S_DIV:  n_state = S_FIN;
            S_FIN:  if (!i_status.out_full) n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // stage commands
    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd.load = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.err  = (r_state == S_ERR);
    assign o_cmd.mul  = (r_state == S_MUL);
    assign o_cmd.acc  = (r_state == S_ACC);
    assign o_cmd.mag  = (r_state == S_MAG);
    assign o_cmd.scl  = (r_state == S_SCL);
    assign o_cmd.div  = (r_state == S_DIV);
    assign o_cmd.fin  = (r_state == S_FIN) && !i_status.out_full;

endmodule

FILE: hdl/dwpid_dp.sv
// ---------------------------------------------------------------------------
// dwpid_dp
// two-lane pid datapath: error and integrator update, gain products, sum,
// magnitude clamp, speed scaling, division by 127 and the result register
// ---------------------------------------------------------------------------
module dwpid_dp import dwpid_pkg::*; #(
    parameter int COUNT_WIDTH    = DEF_COUNT_WIDTH,
    parameter int GAIN_FRAC_BITS = DEF_GAIN_FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cfg                          i_cfg,
    input  t_dp_cmd                       i_cmd,
    output t_dp_status                    o_status,
    input  logic                          i_start_req,
    input  logic signed [COUNT_WIDTH-1:0] i_left_count,
    input  logic signed [COUNT_WIDTH-1:0] i_right_count,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic signed [DRIVE_W-1:0]     o_left_drive,
    output logic signed [DRIVE_W-1:0]     o_right_drive,
    output logic                          o_timed_out
);

    localparam int LANES  = 2;
    localparam int ERR_W  = ((COUNT_WIDTH > TARGET_W) ? COUNT_WIDTH : TARGET_W) + 2;
    localparam int DE_W   = ERR_W + 1;
    localparam int SUM_W  = ((ERR_W > INTEG_W) ? ERR_W : INTEG_W) + 1;
    localparam int PP_W   = ERR_W + GAIN_W + 1;
    localparam int PD_W   = DE_W + GAIN_W + 1;
    localparam int PI_W   = INTEG_W + GAIN_W + 1;
    localparam int ACC_W  = ((PD_W > PI_W) ? PD_W : PI_W) + 2;
    // scaled magnitude at which the drive saturates: 128 * 127 << frac
    localparam int     SAT_LIM = (DRIVE_MAX + 1) * SPEED_DIV;
    localparam longint CLAMP   = longint'(SAT_LIM) << GAIN_FRAC_BITS;
    localparam int MAG_W  = $clog2(CLAMP + 1);
    localparam int PROD_W = MAG_W + SPEED_W;
    localparam int X_W    = $clog2(SAT_LIM);
    localparam int XM_W   = X_W + $clog2(RECIP_MUL);
    localparam int Q_W    = XM_W - RECIP_SHIFT;
    localparam int R_W    = X_W + 1;

    localparam logic signed [ACC_W-1:0]   CLAMP_S = ACC_W'(CLAMP);
    localparam logic [MAG_W-1:0]          CLAMP_M = MAG_W'(CLAMP);
    localparam logic [PROD_W-1:0]         CLAMP_P = PROD_W'(CLAMP);
    localparam logic signed [INTEG_W-1:0] INT_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
    localparam logic signed [INTEG_W-1:0] INT_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

    // captured item
    logic [COUNT_WIDTH-1:0] r_count [LANES];
    logic                   r_start;

    // controller state kept across ticks
    logic signed [INTEG_W-1:0] r_integ [LANES];
    logic signed [ERR_W-1:0]   r_prev  [LANES];
    logic [WINDOW_W-1:0]       r_window_cnt;
    logic [TIMEOUT_W-1:0]      r_elapsed;
    logic                      r_finished;

    // per-tick working registers
    logic                      r_skip;
    logic signed [ERR_W-1:0]   r_err  [LANES];
    logic signed [DE_W-1:0]    r_de   [LANES];
    logic signed [INTEG_W-1:0] r_sum  [LANES];
    logic signed [PP_W-1:0]    r_pp   [LANES];
    logic signed [PD_W-1:0]    r_pd   [LANES];
    logic signed [PI_W-1:0]    r_pi   [LANES];
    logic signed [ACC_W-1:0]   r_acc  [LANES];
    logic [MAG_W-1:0]          r_mag  [LANES];
    logic                      r_neg  [LANES];
    logic [PROD_W-1:0]         r_prod [LANES];
    logic [X_W-1:0]            r_x    [LANES];
    logic [Q_W-1:0]            r_q0   [LANES];
    logic                      r_sat  [LANES];

    // result register
    logic                      r_out_valid;
    logic signed [DRIVE_W-1:0] r_left;
    logic signed [DRIVE_W-1:0] r_right;
    logic                      r_timed_out;

    // combinational values
    logic [COUNT_WIDTH-1:0]    cnt_abs   [LANES];
    logic signed [ERR_W-1:0]   err_w     [LANES];
    logic signed [ERR_W-1:0]   prev_eff  [LANES];
    logic signed [INTEG_W-1:0] integ_eff [LANES];
    logic signed [DE_W-1:0]    de_w      [LANES];
    logic signed [SUM_W-1:0]   sum_w     [LANES];
    logic signed [INTEG_W-1:0] sum_sat   [LANES];
    logic [ACC_W-1:0]          acc_abs   [LANES];
    logic                      acc_big   [LANES];
    logic [MAG_W-1:0]          mag_w     [LANES];
    logic [XM_W-1:0]           xm_w      [LANES];
    logic [R_W-1:0]            rem_w     [LANES];
    logic [Q_W-1:0]            quo_w     [LANES];
    logic signed [DRIVE_W-1:0] dmag_w    [LANES];
    logic signed [DRIVE_W-1:0] drive_w   [LANES];
    logic [WINDOW_W-1:0]       window_n;
    logic                      window_hit;
    logic [TIMEOUT_W-1:0]      elapsed_eff;
    logic [TIMEOUT_W-1:0]      elapsed_n;
    logic                      fin_eff;

    // start request clears the kept state ahead of this tick
    assign fin_eff     = !r_start && r_finished;
    assign window_n    = (r_start ? '0 : r_window_cnt) + WINDOW_W'(1);
    assign window_hit  = (window_n >= i_cfg.window);
    assign elapsed_eff = r_start ? '0 : r_elapsed;
    assign elapsed_n   = (elapsed_eff == '1) ? elapsed_eff : elapsed_eff + TIMEOUT_W'(1);

    // error, derivative and saturating integrator sum per lane
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            cnt_abs[k]   = r_count[k][COUNT_WIDTH-1] ? (~r_count[k] + COUNT_WIDTH'(1))
                                                     : r_count[k];
            err_w[k]     = $signed({{(ERR_W-TARGET_W){1'b0}}, i_cfg.target})
                         - $signed({{(ERR_W-COUNT_WIDTH){1'b0}}, cnt_abs[k]});
            prev_eff[k]  = r_start ? '0 : r_prev[k];
            integ_eff[k] = r_start ? '0 : r_integ[k];
            de_w[k]      = DE_W'(err_w[k]) - DE_W'(prev_eff[k]);
            sum_w[k]     = SUM_W'(integ_eff[k]) + SUM_W'(err_w[k]);
            if ((&sum_w[k][SUM_W-1:INTEG_W-1]) || !(|sum_w[k][SUM_W-1:INTEG_W-1])) begin
                sum_sat[k] = sum_w[k][INTEG_W-1:0];
            end else begin
                sum_sat[k] = sum_w[k][SUM_W-1] ? INT_MIN : INT_MAX;
            end
        end
    end

    // magnitude clamp, reciprocal product and final drive per lane
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            acc_abs[k] = r_acc[k][ACC_W-1] ? ACC_W'(-r_acc[k]) : ACC_W'(r_acc[k]);
            acc_big[k] = (r_acc[k] > CLAMP_S) || (r_acc[k] < -CLAMP_S);
            mag_w[k]   = acc_big[k] ? CLAMP_M : acc_abs[k][MAG_W-1:0];
            xm_w[k]    = XM_W'(r_prod[k][GAIN_FRAC_BITS +: X_W]) * XM_W'(RECIP_MUL);
            rem_w[k]   = R_W'(r_x[k]) - R_W'(r_q0[k] * SPEED_DIV);
            quo_w[k]   = (rem_w[k] >= R_W'(SPEED_DIV)) ? r_q0[k] + Q_W'(1) : r_q0[k];
            dmag_w[k]  = r_sat[k] ? DRIVE_W'(DRIVE_MAX) : DRIVE_W'(quo_w[k]);
            drive_w[k] = r_neg[k] ? -dmag_w[k] : dmag_w[k];
        end
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_count[0] <= i_left_count;
            r_count[1] <= i_right_count;
            r_start    <= i_start_req;
        end
    end

    // kept state, updated once per computed tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LANES; k++) begin
                r_integ[k] <= '0;
                r_prev[k]  <= '0;
            end
            r_window_cnt <= '0;
            r_elapsed    <= '0;
            r_finished   <= 1'b0;
        end else if (i_cmd.err && !fin_eff) begin
            for (int k = 0; k < LANES; k++) begin
                r_prev[k]  <= err_w[k];
                r_integ[k] <= window_hit ? '0 : sum_sat[k];
            end
            r_window_cnt <= window_hit ? '0 : window_n;
            r_elapsed    <= elapsed_n;
            r_finished   <= (elapsed_n >= i_cfg.timeout);
        end
    end

    // working stages
    always_ff @(posedge i_clk) begin
        if (i_cmd.err) begin
            r_skip <= fin_eff;
        end
        for (int k = 0; k < LANES; k++) begin
            if (i_cmd.err) begin
                r_err[k] <= err_w[k];
                r_de[k]  <= de_w[k];
                r_sum[k] <= sum_sat[k];
            end
            // gain products
            if (i_cmd.mul) begin
                r_pp[k] <= $signed({1'b0, i_cfg.gain_prop}) * r_err[k];
                r_pd[k] <= $signed({1'b0, i_cfg.gain_deriv}) * r_de[k];
                r_pi[k] <= $signed({1'b0, i_cfg.gain_integ}) * r_sum[k];
            end
            if (i_cmd.acc) begin
                r_acc[k] <= ACC_W'(r_pp[k]) + ACC_W'(r_pd[k]) + ACC_W'(r_pi[k]);
            end
            // sign goes ahead of the division so truncation is symmetric
            if (i_cmd.mag) begin
                r_mag[k] <= mag_w[k];
                r_neg[k] <= r_acc[k][ACC_W-1] ^ i_cfg.reverse;
            end
            if (i_cmd.scl) begin
                r_prod[k] <= PROD_W'(r_mag[k]) * PROD_W'(i_cfg.speed);
            end
            // dropping the fraction bits first leaves a divide by 127
            if (i_cmd.div) begin
                r_x[k]   <= r_prod[k][GAIN_FRAC_BITS +: X_W];
                r_q0[k]  <= xm_w[k][XM_W-1:RECIP_SHIFT];
                r_sat[k] <= (r_prod[k] >= CLAMP_P);
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.fin) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_left      <= r_skip ? '0 : drive_w[0];
            r_right     <= r_skip ? '0 : drive_w[1];
            r_timed_out <= r_skip;
        end
    end

    assign o_status.skip     = fin_eff;
    assign o_status.out_full = r_out_valid && !i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_left_drive  = r_left;
    assign o_right_drive = r_right;
    assign o_timed_out   = r_timed_out;

endmodule

FILE: hdl/dual_wheel_pid_distance_control_top.sv
// ---------------------------------------------------------------------------
// dual_wheel_pid_distance_control_top
// two-channel pid drive controller for a left and a right wheel
// ---------------------------------------------------------------------------
// Each item is one control tick with both encoder counts; it returns one
// result with the left and right drive in -127..127 and a timed-out flag.
// The block works on one tick at a time: an accepted item runs through a
// seven-step sequence (error and integrator update, gain products, sum,
// magnitude clamp, speed scaling, divide by 127, result load), and a new
// item is taken only once the block is idle again. A tick after the
// timeout skips the arithmetic. The sequence is the only limit; a result
// held by a stalled output stretches it. Registers are to be written only
// while the block holds no tick in progress; the block does not enforce it.
// ---------------------------------------------------------------------------
module dual_wheel_pid_distance_control_top import dwpid_pkg::*; #(
    parameter int COUNT_WIDTH    = DEF_COUNT_WIDTH,
    parameter int GAIN_FRAC_BITS = DEF_GAIN_FRAC_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dwpid_in_if.sink    i_in,
    dwpid_out_if.source o_out,
    dwpid_cfg_if.sink   i_cfg
);

    t_cfg       cfg;
    t_dp_cmd    cmd;
    t_dp_status status;

    // register file
    dwpid_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (i_cfg.valid),
        .i_wr_index (i_cfg.index),
        .i_wr_data  (i_cfg.data),
        .o_wr_ready (i_cfg.ready),
        .o_cfg      (cfg)
    );

    // sequencer
    dwpid_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // datapath
    dwpid_dp #(
        .COUNT_WIDTH    (COUNT_WIDTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_start_req   (i_in.start_req),
        .i_left_count  (i_in.left_count),
        .i_right_count (i_in.right_count),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_left_drive  (o_out.left_drive),
        .o_right_drive (o_out.right_drive),
        .o_timed_out   (o_out.timed_out)
    );

endmodule

FILE: hdl/dwpid_chk.sv
// ---------------------------------------------------------------------------
// dwpid_chk
// port-level checks on the drive controller, bound to the top level
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dwpid_chk import dwpid_pkg::*; (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      i_in_ready,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic signed [DRIVE_W-1:0] i_left_drive,
    input logic signed [DRIVE_W-1:0] i_right_drive,
    input logic                      i_timed_out
);

    localparam logic signed [DRIVE_W-1:0] DRIVE_LIM = DRIVE_W'(DRIVE_MAX);

    // drives never reach the most negative code
    `ASSERT_CLK(a_drive_range, i_clk, i_rst_n, i_out_valid |-> (i_left_drive >= -DRIVE_LIM) && (i_right_drive >= -DRIVE_LIM), "drive outside limit")

    // a timed-out result carries zero drive
    `ASSERT_NEVER(a_timeout_zero, i_clk, i_rst_n, i_out_valid && i_timed_out && ((i_left_drive != '0) || (i_right_drive != '0)), "drive while timed out")

    // one tick at a time: busy right after an item is taken
    `ASSERT_CLK(a_busy_after_accept, i_clk, i_rst_n, (i_in_valid && i_in_ready) |=> !i_in_ready, "input ready during a tick")

    // a stalled result holds
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> i_out_valid && $stable({i_left_drive, i_right_drive, i_timed_out}), "stalled result changed")

endmodule

bind dual_wheel_pid_distance_control_top dwpid_chk u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_left_drive  (o_out.left_drive),
    .i_right_drive (o_out.right_drive),
    .i_timed_out   (o_out.timed_out)
);

FILE: tb/dwpid_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dwpid_checker
// watches the tick, drive and register channels of the dual wheel pid
// controller, predicts every drive result and compares it field by field
// ---------------------------------------------------------------------------
module dwpid_checker import dwpid_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    dwpid_in_if  i_in,
    dwpid_out_if i_out,
    dwpid_cfg_if i_cfg,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_results,
    output int   o_timed_out,
    output int   o_saturated
);

    typedef struct packed {
        logic signed [DRIVE_W-1:0] left;
        logic signed [DRIVE_W-1:0] right;
        logic                      timed_out;
    } t_drive_pair;

    localparam longint DRIVE_DIV  = longint'(SPEED_DIV) << DEF_GAIN_FRAC_BITS;
    localparam longint INTEG_HI   = (64'sd1 <<< (INTEG_W - 1)) - 1;
    localparam longint INTEG_LO   = -(64'sd1 <<< (INTEG_W - 1));
    localparam int     REPORT_CAP = 40;

    // shadow of the register file and the per-wheel controller state
    t_cfg                regs;
    longint              left_integ;
    longint              right_integ;
    longint              left_prev;
    longint              right_prev;
    logic [WINDOW_W-1:0] window_cnt;
    logic [15:0]         elapsed;
    logic                finished;

    t_drive_pair pending_drives[$];
    int          mismatch_total;
    int          result_total;
    int          timed_out_total;
    int          saturated_total;

    // one wheel: weighted sum, speed scaling, sign, truncating divide, clamp
    function automatic longint wheel_drive(longint err, longint prev, longint integ);
        longint gp;
        longint gi;
        longint gd;
        longint spd;
        longint acc;
        longint q;
        gp  = regs.gain_prop;
        gi  = regs.gain_integ;
        gd  = regs.gain_deriv;
        spd = regs.speed;
        acc = gp * err + gd * (err - prev) + gi * integ;
        acc = acc * spd;
        if (regs.reverse) begin
            acc = -acc;
        end
        q = acc / DRIVE_DIV;
        if (q > DRIVE_MAX) begin
            q = DRIVE_MAX;
        end
        if (q < -DRIVE_MAX) begin
            q = -DRIVE_MAX;
        end
        return q;
    endfunction

    function automatic longint clamp_integ(longint v);
        if (v > INTEG_HI) begin
            return INTEG_HI;
        end
        if (v < INTEG_LO) begin
            return INTEG_LO;
        end
        return v;
    endfunction

    // advance the controller by one tick and return the drives it gives
    function automatic t_drive_pair predict_tick(
        logic                              start,
        logic signed [DEF_COUNT_WIDTH-1:0] lc,
        logic signed [DEF_COUNT_WIDTH-1:0] rc
    );
        t_drive_pair res;
        longint      tgt;
        longint      lmag;
        longint      rmag;
        longint      lerr;
        longint      rerr;
        if (start) begin
            left_integ  = 0;
            right_integ = 0;
            left_prev   = 0;
            right_prev  = 0;
            window_cnt  = '0;
            elapsed     = '0;
            finished    = 1'b0;
        end
        // move over: zero drive, no state change
        if (finished) begin
            res.left      = '0;
            res.right     = '0;
            res.timed_out = 1'b1;
            return res;
        end
        tgt  = regs.target;
        lmag = lc;
        rmag = rc;
        if (lmag < 0) begin
            lmag = -lmag;
        end
        if (rmag < 0) begin
            rmag = -rmag;
        end
        lerr        = tgt - lmag;
        rerr        = tgt - rmag;
        left_integ  = clamp_integ(left_integ + lerr);
        right_integ = clamp_integ(right_integ + rerr);
        window_cnt  = window_cnt + 1'b1;
        res.left      = DRIVE_W'(wheel_drive(lerr, left_prev, left_integ));
        res.right     = DRIVE_W'(wheel_drive(rerr, right_prev, right_integ));
        res.timed_out = 1'b0;
        left_prev  = lerr;
        right_prev = rerr;
        // integrator window
        if (window_cnt >= regs.window) begin
            left_integ  = 0;
            right_integ = 0;
            window_cnt  = '0;
        end
        // elapsed count saturates, timeout ends the move
        if (elapsed != 16'hFFFF) begin
            elapsed = elapsed + 1'b1;
        end
        if (elapsed >= regs.timeout) begin
            finished = 1'b1;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string field, input longint got, input longint want);
        mismatch_total++;
        if (mismatch_total <= REPORT_CAP) begin
            $display("[%0t] result %0d: %s is %0d, expected %0d",
                     $time, result_total, field, got, want);
        end
    endtask

    // sample all three channels at the rising edge
    always @(posedge i_clk) begin
        t_drive_pair got;
        t_drive_pair want;
        if (!i_rst_n) begin
            regs = '{RST_TARGET, RST_GAIN_P, RST_GAIN_I, RST_GAIN_D, RST_SPEED,
                     RST_REVERSE, RST_TIMEOUT, RST_WINDOW};
            left_integ  = 0;
            right_integ = 0;
            left_prev   = 0;
            right_prev  = 0;
            window_cnt  = '0;
            elapsed     = '0;
            finished    = 1'b0;
            pending_drives.delete();
        end else begin
            // register writes
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_TARGET:  regs.target     = i_cfg.data[TARGET_W-1:0];
                    REG_GAIN_P:  regs.gain_prop  = i_cfg.data[GAIN_W-1:0];
                    REG_GAIN_I:  regs.gain_integ = i_cfg.data[GAIN_W-1:0];
                    REG_GAIN_D:  regs.gain_deriv = i_cfg.data[GAIN_W-1:0];
                    REG_SPEED:   regs.speed      = i_cfg.data[SPEED_W-1:0];
                    REG_REVERSE: regs.reverse    = i_cfg.data[0];
                    REG_TIMEOUT: regs.timeout    = i_cfg.data[TIMEOUT_W-1:0];
                    REG_WINDOW:  regs.window     = i_cfg.data[WINDOW_W-1:0];
                    default: ;
                endcase
            end
            // drive results against the oldest prediction
            if (i_out.valid && i_out.ready) begin
                got = '{i_out.left_drive, i_out.right_drive, i_out.timed_out};
                result_total++;
                if (pending_drives.size() == 0) begin
                    report_mismatch("unexpected result, left_drive", got.left, 0);
                end else begin
                    want = pending_drives.pop_front();
                    if (got.left != want.left) begin
                        report_mismatch("left_drive", got.left, want.left);
                    end
                    if (got.right != want.right) begin
                        report_mismatch("right_drive", got.right, want.right);
                    end
                    if (got.timed_out != want.timed_out) begin
                        report_mismatch("timed_out", got.timed_out, want.timed_out);
                    end
                    if (want.timed_out) begin
                        timed_out_total++;
                    end
                    if (want.left == DRIVE_MAX || want.left == -DRIVE_MAX ||
                        want.right == DRIVE_MAX || want.right == -DRIVE_MAX) begin
                        saturated_total++;
                    end
                end
            end
            // accepted ticks
            if (i_in.valid && i_in.ready) begin
                pending_drives.push_back(
                    predict_tick(i_in.start_req, i_in.left_count, i_in.right_count));
            end
        end
        o_fail_count <= mismatch_total;
        o_pending    <= pending_drives.size();
        o_results    <= result_total;
        o_timed_out  <= timed_out_total;
        o_saturated  <= saturated_total;
    end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// testbench of the dual wheel pid distance controller: directed ticks at the
// count and register extremes, then randomised moves under many register
// settings, with bursty input, a stalling output and one long output hold-off
// ---------------------------------------------------------------------------
module tb import dwpid_pkg::*; ();

    localparam int TICK_GOAL   = 1150;
    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 16;

    logic i_clk = 1'b0;
    logic i_rst_n;

    int fail_count;
    int pending;
    int results;
    int timed_out_cnt;
    int saturated_cnt;

    int ticks_sent;
    int settings_cnt;
    int burst_left;
    int cycle_cnt;

    dwpid_in_if #(.COUNT_WIDTH(DEF_COUNT_WIDTH)) in_ch ();
    dwpid_out_if out_ch ();
    dwpid_cfg_if cfg_ch ();

    dual_wheel_pid_distance_control_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    dwpid_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_results    (results),
        .o_timed_out  (timed_out_cnt),
        .o_saturated  (saturated_cnt)
    );

    // clock
    always #1 i_clk = ~i_clk;

    // one register write, valid left high for a following write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
    endtask

    task automatic program_regs(
        input logic [15:0] tgt, input logic [15:0] gp, input logic [15:0] gi,
        input logic [15:0] gd, input logic [15:0] spd, input logic [15:0] rev,
        input logic [15:0] tout, input logic [15:0] win
    );
        write_reg(REG_TARGET, tgt);
        write_reg(REG_GAIN_P, gp);
        write_reg(REG_GAIN_I, gi);
        write_reg(REG_GAIN_D, gd);
        write_reg(REG_SPEED, spd);
        write_reg(REG_REVERSE, rev);
        write_reg(REG_TIMEOUT, tout);
        write_reg(REG_WINDOW, win);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        settings_cnt++;
    endtask

    // stop offering ticks and wait for every drive result to come back
    task automatic drain;
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // one tick item, sent in bursts with random gaps in between
    task automatic send_tick(input logic start, input int lc, input int rc);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 11);
            if (gap > 0) begin
                @(negedge i_clk);
                in_ch.valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        @(negedge i_clk);
        in_ch.valid       <= 1'b1;
        in_ch.start_req   <= start;
        in_ch.left_count  <= lc[DEF_COUNT_WIDTH-1:0];
        in_ch.right_count <= rc[DEF_COUNT_WIDTH-1:0];
        do @(posedge i_clk); while (!in_ch.ready);
        ticks_sent++;
    endtask

    // signed encoder count from a magnitude, kept in the 16-bit range
    function automatic int to_count(input int mag, input bit neg);
        int v;
        v = neg ? -mag : mag;
        if (v > 32767) begin
            v = 32767;
        end
        if (v < -32768) begin
            v = -32768;
        end
        return v;
    endfunction

    function automatic logic [15:0] pick_gain;
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom);
            default: return 16'($urandom_range(0, 1024));
        endcase
    endfunction

    // cycle limit
    initial begin : watchdog
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("run stopped at the cycle limit with %0d results outstanding", pending);
        $display("FAIL dual_wheel_pid_distance_control_top");
        $finish;
    end

    // result side: stall patterns plus one long hold-off while ticks are offered
    initial begin : drive_sink
        int  mode;
        int  span;
        bit  held_off;
        out_ch.ready = 1'b0;
        held_off     = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 120);
            repeat (span) begin
                @(negedge i_clk);
                if (!held_off && results >= HOLD_AT && in_ch.valid) begin
                    held_off = 1'b1;
                    out_ch.ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(negedge i_clk);
                end
                case (mode)
                    0:       out_ch.ready <= 1'b1;
                    1:       out_ch.ready <= 1'($urandom_range(0, 1));
                    2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: out_ch.ready <= ($urandom_range(0, 4) != 0);
                endcase
            end
        end
    end

    // stimulus and verdict
    initial begin : stimulus
        logic [15:0] tgt;
        logic [15:0] spd;
        logic [15:0] tout;
        logic [15:0] win;
        int          phase_len;
        int          move_len;
        int          step_max;
        int          pos;
        int          lmag;
        int          rmag;
        bit          lneg;
        bit          rneg;
        bit          well_formed;

        i_rst_n           = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.start_req   = 1'b0;
        in_ch.left_count  = '0;
        in_ch.right_count = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = REG_TARGET;
        cfg_ch.data       = '0;
        ticks_sent        = 0;
        settings_cnt      = 0;
        burst_left        = 0;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // default gains, short timeout and window; count extremes, run past timeout
        program_regs(16'd1000, RST_GAIN_P, RST_GAIN_I, RST_GAIN_D, 16'(RST_SPEED),
                     16'd0, 16'd12, 16'd3);
        send_tick(1'b1, 0, 0);
        send_tick(1'b0, 32767, -32768);
        send_tick(1'b0, -1, 1);
        send_tick(1'b0, 1000, -1000);
        send_tick(1'b0, -32768, 32767);
        send_tick(1'b0, 500, -700);
        for (int i = 0; i < 8; i++) begin
            send_tick(1'b0, 110 * i, -90 * i);
        end
        send_tick(1'b1, 0, 0);
        send_tick(1'b0, int'($signed(16'($urandom))), int'($signed(16'($urandom))));
        drain();

        // everything at the top, reversed, zero timeout and zero window
        program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd127, 16'd1, 16'd0, 16'd0);
        send_tick(1'b1, -32768, 32767);
        send_tick(1'b0, 0, 0);
        send_tick(1'b1, 0, 0);
        drain();

        // everything at the bottom, longest timeout and window
        program_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF, 16'd255);
        send_tick(1'b1, 1234, -4321);
        send_tick(1'b0, -32768, 0);
        send_tick(1'b0, 0, 32767);
        drain();

        // random register settings, each followed by a run of moves
        while (ticks_sent < TICK_GOAL) begin
            case ($urandom_range(0, 7))
                0:       tgt = 16'd0;
                1:       tgt = 16'hFFFF;
                2:       tgt = 16'($urandom);
                default: tgt = 16'($urandom_range(0, 3000));
            endcase
            case ($urandom_range(0, 5))
                0:       spd = 16'd0;
                1:       spd = 16'd127;
                default: spd = 16'($urandom_range(1, 126));
            endcase
            case ($urandom_range(0, 9))
                0:       tout = 16'd0;
                1:       tout = 16'hFFFF;
                2:       tout = 16'($urandom);
                default: tout = 16'($urandom_range(1, 60));
            endcase
            case ($urandom_range(0, 9))
                0:       win = 16'd1;
                1:       win = 16'd255;
                default: win = 16'($urandom_range(1, 40));
            endcase
            program_regs(tgt, pick_gain(), pick_gain(), pick_gain(), spd,
                         16'($urandom_range(0, 1)), tout, win);

            phase_len = $urandom_range(20, 80);
            while (phase_len > 0) begin
                move_len = $urandom_range(3, 40);
                if (move_len > phase_len) begin
                    move_len = phase_len;
                end
                phase_len   -= move_len;
                well_formed = ($urandom_range(0, 9) != 0);
                lneg        = 1'($urandom_range(0, 1));
                rneg        = 1'($urandom_range(0, 1));
                step_max    = int'(tgt) / 8 + 4;
                pos         = 0;
                for (int k = 0; k < move_len; k++) begin
                    pos += $urandom_range(0, step_max);
                    if ($urandom_range(0, 9) == 0) begin
                        // noise item: raw counts, occasional restart
                        send_tick($urandom_range(0, 7) == 0,
                                  int'($signed(16'($urandom))),
                                  int'($signed(16'($urandom))));
                    end else begin
                        lmag = pos + $urandom_range(0, 40) - 20;
                        rmag = pos + $urandom_range(0, 40) - 20;
                        if (lmag < 0) begin
                            lmag = 0;
                        end
                        if (rmag < 0) begin
                            rmag = 0;
                        end
                        // a broken move carries on without its start
                        send_tick(well_formed && k == 0,
                                  to_count(lmag, lneg), to_count(rmag, rneg));
                    end
                end
            end
            drain();
        end

        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("ran %0d ticks under %0d register settings with bursty input",
                 ticks_sent, settings_cnt);
        $display("checked %0d results: %0d after timeout, %0d with a saturated drive",
                 results, timed_out_cnt, saturated_cnt);
        if (fail_count == 0) begin
            $display("PASS dual_wheel_pid_distance_control_top");
        end else begin
            $display("FAIL dual_wheel_pid_distance_control_top");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+hdl
hdl/dwpid_pkg.sv
hdl/dwpid_ifs.sv
hdl/dwpid_regs.sv
hdl/dwpid_ctrl.sv
hdl/dwpid_dp.sv
hdl/dual_wheel_pid_distance_control_top.sv
hdl/dwpid_chk.sv
tb/dwpid_checker.sv
tb/tb.sv
